// File: src/mas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mas_pkg;

   typedef enum logic [3:0] {
      ST_BOOT   = 4'd0,
      ST_IDLE   = 4'd1,
      ST_OFFS   = 4'd2,
      ST_MCAL   = 4'd3,
      ST_ECAL   = 4'd4,
      ST_READY  = 4'd5,
      ST_CLOSED = 4'd6,
      ST_PWMT   = 4'd7,
      ST_ENCT   = 4'd8,
      ST_ADCT   = 4'd9,
      ST_OPENL  = 4'd10,
      ST_FAULT  = 4'd11
   } axis_state_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_DISABLE = 3'd1,
      ACT_OFFS    = 3'd2,
      ACT_RES     = 3'd3,
      ACT_ENC     = 3'd4,
      ACT_FULL    = 3'd5,
      ACT_PWM     = 3'd6
   } entry_action_type;

   typedef enum logic [2:0] {
      PC_HOLD    = 3'd0,
      PC_DISABLE = 3'd1,
      PC_FULL    = 3'd2,
      PC_CAL     = 3'd3,
      PC_SAFE    = 3'd4
   } power_cmd_type;

   typedef enum logic [2:0] {
      FC_NONE = 3'd0,
      FC_EXT  = 3'd1,
      FC_PWM  = 3'd2,
      FC_ENC  = 3'd3,
      FC_MOT  = 3'd4
   } fault_code_type;

   typedef enum logic {
      KIND_TICK    = 1'b0,
      KIND_REQUEST = 1'b1
   } item_kind_type;

   typedef enum logic [1:0] {
      CAL_RUNNING = 2'd0,
      CAL_DONE    = 2'd1,
      CAL_FAILED  = 2'd2
   } calib_status_type;

   typedef struct packed {
      logic       req_type;
      logic [3:0] req_state;
      logic       external_fault;
      logic       power_safe_ok;
      logic       full_enable_ok;
      logic       calib_enable_ok;
      logic [1:0] calib_status;
      logic       offset_valid;
      logic       motor_cal_valid;
      logic       encoder_cal_valid;
   } req_item_type;

   typedef struct packed {
      logic [3:0] axis_state;
      logic       fault_active;
      logic [2:0] entry_action;
      logic [2:0] power_cmd;
      logic [2:0] fault_code;
      logic       ready_for_loop;
      logic       open_loop_drive;
      logic       outer_loop_run;
   } rsp_item_type;

   // Everything the supervisor carries from one item to the next.
   typedef struct packed {
      axis_state_type state;
      logic [3:0]     pending;
      fault_code_type fault;
   } sup_state_type;

   function automatic entry_action_type entry_action_of(input axis_state_type st);
      entry_action_type act;
      unique case (st)
         ST_IDLE, ST_ENCT, ST_ADCT: act = ACT_DISABLE;
         ST_OFFS:                   act = ACT_OFFS;
         ST_MCAL:                   act = ACT_RES;
         ST_ECAL:                   act = ACT_ENC;
         ST_CLOSED:                 act = ACT_FULL;
         ST_PWMT:                   act = ACT_PWM;
         default:                   act = ACT_NONE;
      endcase
      return act;
   endfunction

   function automatic power_cmd_type entry_power_of(input axis_state_type st);
      power_cmd_type pc;
      unique case (st)
         ST_IDLE, ST_ENCT, ST_ADCT: pc = PC_DISABLE;
         ST_CLOSED:                 pc = PC_FULL;
         ST_OPENL:                  pc = PC_CAL;
         ST_FAULT:                  pc = PC_SAFE;
         default:                   pc = PC_HOLD;
      endcase
      return pc;
   endfunction

endpackage

`default_nettype wire

// File: src/mas_step.sv
`timescale 1ns / 1ps
`default_nettype none

module mas_step (
   input  mas_pkg::sup_state_type cur,
   input  mas_pkg::req_item_type  item,
   output mas_pkg::sup_state_type nxt,
   output mas_pkg::rsp_item_type  rsp
);
   import mas_pkg::*;

   logic is_tick;
   logic all_cal;

   assign is_tick = (item.req_type == KIND_TICK);
   assign all_cal = item.offset_valid && item.motor_cal_valid && item.encoder_cal_valid;

   // Next state, pending request and latched fault.
   always_comb begin
      nxt = cur;
      if (!is_tick) begin
         nxt.pending = item.req_state;
      end else if ((item.external_fault || cur.fault != FC_NONE) && cur.state != ST_FAULT) begin
         nxt.state = ST_FAULT;
         if (item.external_fault && cur.fault == FC_NONE) begin
            nxt.fault = FC_EXT;
         end
      end else begin
         // Past the fault check either the axis is already in fault or the latched code is clear.
         unique case (cur.state)
            ST_BOOT: begin
               if (item.power_safe_ok) begin
                  nxt.state = ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (cur.pending == ST_OFFS) begin
                  nxt.state = ST_OFFS;
               end else if (cur.pending == ST_MCAL && item.offset_valid) begin
                  nxt.state = ST_MCAL;
               end else if (cur.pending == ST_ECAL && item.motor_cal_valid) begin
                  nxt.state = ST_ECAL;
               end else if (cur.pending >= ST_PWMT && cur.pending <= ST_OPENL) begin
                  nxt.state = axis_state_type'(cur.pending);
                  if (cur.pending == ST_OPENL && !item.calib_enable_ok) begin
                     nxt.fault = FC_PWM;
                  end
               end
            end
            ST_OFFS, ST_MCAL, ST_ECAL: begin
               if (item.calib_status == CAL_DONE) begin
                  nxt.state = all_cal ? ST_READY : ST_IDLE;
               end else if (item.calib_status == CAL_FAILED) begin
                  nxt.fault = (cur.state == ST_ECAL) ? FC_ENC : FC_MOT;
               end
            end
            ST_READY: begin
               if (cur.pending == ST_CLOSED && all_cal) begin
                  nxt.state = ST_CLOSED;
                  if (!item.full_enable_ok) begin
                     nxt.fault = FC_PWM;
                  end
               end
            end
            ST_PWMT, ST_ENCT, ST_ADCT: begin
               if (cur.pending == ST_IDLE) begin
                  nxt.state = ST_IDLE;
               end
            end
            ST_OPENL: begin
               if (cur.pending == ST_IDLE) begin
                  nxt.state = ST_IDLE;
               end else if (!item.calib_enable_ok) begin
                  nxt.fault = FC_PWM;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result fields. A state change reports the entry action of the new state,
   // which also covers the move into fault.
   always_comb begin
      rsp                = '0;
      rsp.axis_state     = nxt.state;
      rsp.fault_active   = (nxt.state == ST_FAULT);
      rsp.fault_code     = nxt.fault;
      rsp.entry_action   = ACT_NONE;
      rsp.power_cmd      = PC_HOLD;
      if (is_tick) begin
         if (nxt.state != cur.state) begin
            rsp.entry_action = entry_action_of(nxt.state);
            rsp.power_cmd    = entry_power_of(nxt.state);
         end else if (cur.state == ST_OPENL) begin
            rsp.power_cmd       = PC_CAL;
            rsp.open_loop_drive = item.calib_enable_ok;
         end else if (cur.state == ST_CLOSED) begin
            rsp.outer_loop_run = 1'b1;
         end else if (cur.state == ST_FAULT) begin
            rsp.power_cmd = PC_DISABLE;
         end
         rsp.ready_for_loop = (nxt.state == ST_READY) && all_cal && !item.external_fault
                              && (nxt.fault == FC_NONE);
      end
   end

endmodule

`default_nettype wire

// File: src/motor_axis_supervisor_fsm.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Ports                             Carries
// req      in         req_valid, req_ready, req_item    state request or 1 kHz tick
// rsp      out        rsp_valid, rsp_ready, rsp_item    state, action, power command
//
// Each result passes through the input register and then the result register, and a
// stalled result register holds it back. Without a stall, one item is taken every
// cycle.
// The supervisor state advances when an item moves into the result register.
// Reset puts the axis in boot with no pending request and no latched fault.
// A stalled result holds its register; the input register takes one more item
// only while it is empty, and req_ready then stays low until the result is taken.

module motor_axis_supervisor_fsm (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  mas_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output mas_pkg::rsp_item_type rsp_item
);
   import mas_pkg::*;

   logic          s1_valid_ff;
   req_item_type  s1_item_ff;
   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff;
   sup_state_type sup_ff;
   sup_state_type sup_in;
   rsp_item_type  rsp_item_in;
   logic          advance;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   mas_step u_step (
      .cur  (sup_ff),
      .item (s1_item_ff),
      .nxt  (sup_in),
      .rsp  (rsp_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sup_ff.state   <= ST_BOOT;
         sup_ff.pending <= ST_BOOT;
         sup_ff.fault   <= FC_NONE;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               sup_ff <= sup_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_item_ff <= req_item;
      end
      if (advance && s1_valid_ff) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // The fault state is absorbing.
   a_fault_absorbing: assert property (@(posedge clock) disable iff (reset)
      sup_ff.state == ST_FAULT |=> sup_ff.state == ST_FAULT)
      else $error("axis left the fault state");

   // Only the first fault cause is kept.
   a_fault_kept: assert property (@(posedge clock) disable iff (reset)
      sup_ff.fault != FC_NONE |=> $stable(sup_ff.fault))
      else $error("latched fault code changed");

   // The supervisor state moves only when an item is processed.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && s1_valid_ff) |=> $stable(sup_ff))
      else $error("supervisor state changed without an item");

   // Ready for the loop only in the ready state with no fault.
   a_ready_loop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.ready_for_loop |->
         rsp_item_ff.axis_state == ST_READY && rsp_item_ff.fault_code == FC_NONE)
      else $error("ready_for_loop outside a clean ready state");

endmodule

`default_nettype wire

// File: tb/motor_axis_supervisor_fsm_tb.sv
`timescale 1ns / 1ps

module motor_axis_supervisor_fsm_tb;
   import mas_pkg::*;

   // Calibration status 3 is not a defined code; the block treats it as running.
   localparam logic [1:0] CAL_UNUSED = 2'd3;
   // Request values that match no transition.
   localparam logic [3:0] REQ_UNDEFINED = 4'hF;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;

   motor_axis_supervisor_fsm u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // Predicted supervisor state and the reports still owed by the block.
   sup_state_type axis_now = '{state: ST_BOOT, pending: ST_BOOT, fault: FC_NONE};
   rsp_item_type  reports_due[$];

   int unsigned stall_pct     = 23;
   bit          allow_ready   = 1'b0;
   bit          allow_closed  = 1'b0;
   bit          allow_fault   = 1'b0;
   int unsigned mismatches    = 0;
   int unsigned ticks_sent    = 0;
   int unsigned requests_sent = 0;
   int unsigned reports_seen  = 0;
   bit [15:0]   states_seen   = '0;

   axis_state_type useful_requests [9] = '{ST_IDLE, ST_OFFS, ST_MCAL, ST_ECAL, ST_CLOSED,
                                           ST_PWMT, ST_ENCT, ST_ADCT, ST_OPENL};

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic void latch_fault(inout fault_code_type fc, input fault_code_type code);
      if (fc == FC_NONE) fc = code;
   endfunction

   function automatic void enter_state(input axis_state_type to, input logic full_ok,
                                       input logic cal_ok, inout axis_state_type st,
                                       inout entry_action_type act, inout power_cmd_type pc,
                                       inout fault_code_type fc);
      st  = to;
      act = ACT_NONE;
      pc  = PC_HOLD;
      case (to)
         ST_IDLE, ST_ENCT, ST_ADCT: begin
            act = ACT_DISABLE;
            pc  = PC_DISABLE;
         end
         ST_OFFS: act = ACT_OFFS;
         ST_MCAL: act = ACT_RES;
         ST_ECAL: act = ACT_ENC;
         ST_CLOSED: begin
            act = ACT_FULL;
            pc  = PC_FULL;
            if (!full_ok) latch_fault(fc, FC_PWM);
         end
         ST_PWMT: act = ACT_PWM;
         ST_OPENL: begin
            pc = PC_CAL;
            if (!cal_ok) latch_fault(fc, FC_PWM);
         end
         ST_FAULT: pc = PC_SAFE;
         default: ;
      endcase
   endfunction

   function automatic rsp_item_type predict_axis_report(input sup_state_type cur,
                                                        input req_item_type it,
                                                        output sup_state_type nxt);
      rsp_item_type     r;
      axis_state_type   st;
      logic [3:0]       want;
      fault_code_type   fc;
      entry_action_type act;
      power_cmd_type    pc;
      logic             all_cal;
      logic             ext;
      logic             entered_fault;
      logic             drive;
      logic             outer;
      logic             ready;
      st            = cur.state;
      want          = cur.pending;
      fc            = cur.fault;
      act           = ACT_NONE;
      pc            = PC_HOLD;
      drive         = 1'b0;
      outer         = 1'b0;
      ready         = 1'b0;
      entered_fault = 1'b0;
      nxt           = cur;
      ext           = it.external_fault;
      all_cal       = it.offset_valid && it.motor_cal_valid && it.encoder_cal_valid;
      if (it.req_type == KIND_REQUEST) begin
         nxt.pending = it.req_state;
      end else begin
         // A fault takes over the whole tick; the first cause stays latched.
         if ((ext || fc != FC_NONE) && st != ST_FAULT) begin
            if (ext) latch_fault(fc, FC_EXT);
            enter_state(ST_FAULT, it.full_enable_ok, it.calib_enable_ok, st, act, pc, fc);
            entered_fault = 1'b1;
         end
         case (st)
            ST_BOOT: begin
               if (it.power_safe_ok)
                  enter_state(ST_IDLE, it.full_enable_ok, it.calib_enable_ok, st, act, pc, fc);
            end
            ST_IDLE: begin
               if (want == ST_OFFS)
                  enter_state(ST_OFFS, it.full_enable_ok, it.calib_enable_ok, st, act, pc, fc);
               else if (want == ST_MCAL && it.offset_valid)
                  enter_state(ST_MCAL, it.full_enable_ok, it.calib_enable_ok, st, act, pc, fc);
               else if (want == ST_ECAL && it.motor_cal_valid)
                  enter_state(ST_ECAL, it.full_enable_ok, it.calib_enable_ok, st, act, pc, fc);
               else if (want >= ST_PWMT && want <= ST_OPENL)
                  enter_state(axis_state_type'(want), it.full_enable_ok, it.calib_enable_ok,
                              st, act, pc, fc);
            end
            ST_OFFS, ST_MCAL, ST_ECAL: begin
               if (it.calib_status == CAL_DONE) begin
                  if (all_cal)
                     enter_state(ST_READY, it.full_enable_ok, it.calib_enable_ok,
                                 st, act, pc, fc);
                  else
                     enter_state(ST_IDLE, it.full_enable_ok, it.calib_enable_ok,
                                 st, act, pc, fc);
               end else if (it.calib_status == CAL_FAILED) begin
                  latch_fault(fc, (st == ST_ECAL) ? FC_ENC : FC_MOT);
               end
            end
            ST_READY: begin
               if (want == ST_CLOSED && all_cal && !ext && fc == FC_NONE)
                  enter_state(ST_CLOSED, it.full_enable_ok, it.calib_enable_ok,
                              st, act, pc, fc);
            end
            ST_PWMT, ST_ENCT, ST_ADCT: begin
               if (want == ST_IDLE)
                  enter_state(ST_IDLE, it.full_enable_ok, it.calib_enable_ok, st, act, pc, fc);
            end
            ST_OPENL: begin
               if (want == ST_IDLE) begin
                  enter_state(ST_IDLE, it.full_enable_ok, it.calib_enable_ok, st, act, pc, fc);
               end else begin
                  pc = PC_CAL;
                  if (!it.calib_enable_ok) latch_fault(fc, FC_PWM);
                  else drive = 1'b1;
               end
            end
            ST_CLOSED: outer = 1'b1;
            default: begin
               if (!entered_fault) pc = PC_DISABLE;
            end
         endcase
         ready = all_cal && !ext && fc == FC_NONE && st == ST_READY;
      end
      nxt.state         = st;
      nxt.fault         = fc;
      r.axis_state      = st;
      r.fault_active    = (st == ST_FAULT);
      r.entry_action    = act;
      r.power_cmd       = pc;
      r.fault_code      = fc;
      r.ready_for_loop  = ready;
      r.open_loop_drive = drive;
      r.outer_loop_run  = outer;
      return r;
   endfunction

   // Bends a random item so that the axis does not reach a state it cannot
   // leave before the phase that is meant to go there.
   function automatic req_item_type keep_safe(input req_item_type it);
      req_item_type  v;
      sup_state_type nx;
      rsp_item_type  unused;
      v      = it;
      unused = predict_axis_report(axis_now, v, nx);
      if (!allow_fault && nx.fault != FC_NONE) begin
         v.external_fault  = 1'b0;
         v.full_enable_ok  = 1'b1;
         v.calib_enable_ok = 1'b1;
         if (v.calib_status == CAL_FAILED) v.calib_status = CAL_UNUSED;
         unused = predict_axis_report(axis_now, v, nx);
      end
      if ((!allow_ready && nx.state == ST_READY && axis_now.state != ST_READY) ||
          (!allow_closed && nx.state == ST_CLOSED && axis_now.state != ST_CLOSED))
         v.encoder_cal_valid = 1'b0;
      return v;
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      it.req_type = ($urandom_range(99) < 25) ? KIND_REQUEST : KIND_TICK;
      if ($urandom_range(99) < 85) it.req_state = useful_requests[$urandom_range(8)];
      else it.req_state = 4'($urandom_range(15));
      it.external_fault    = ($urandom_range(99) < 8);
      it.power_safe_ok     = 1'($urandom_range(1));
      it.full_enable_ok    = ($urandom_range(99) < 80);
      it.calib_enable_ok   = ($urandom_range(99) < 80);
      it.calib_status      = 2'($urandom_range(3));
      it.offset_valid      = ($urandom_range(99) < 80);
      it.motor_cal_valid   = ($urandom_range(99) < 80);
      it.encoder_cal_valid = ($urandom_range(99) < 80);
      return keep_safe(it);
   endfunction

   function automatic req_item_type make_tick(input logic psafe, input logic [1:0] cst,
                                              input logic offs, input logic mot,
                                              input logic enc);
      req_item_type it;
      it                   = '0;
      it.req_type          = KIND_TICK;
      it.power_safe_ok     = psafe;
      it.full_enable_ok    = 1'b1;
      it.calib_enable_ok   = 1'b1;
      it.calib_status      = cst;
      it.offset_valid      = offs;
      it.motor_cal_valid   = mot;
      it.encoder_cal_valid = enc;
      return it;
   endfunction

   function automatic req_item_type make_request(input logic [3:0] st);
      req_item_type it;
      it           = '0;
      it.req_type  = KIND_REQUEST;
      it.req_state = st;
      return it;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so the next call may present a new item at once.
   task automatic send_item(input req_item_type it);
      rsp_item_type  report;
      sup_state_type after;
      while ($urandom_range(99) < stall_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      report   = predict_axis_report(axis_now, it, after);
      axis_now = after;
      reports_due.push_back(report);
      states_seen[report.axis_state] = 1'b1;
      if (it.req_type == KIND_REQUEST) requests_sent++;
      else ticks_sent++;
      @(negedge clock);
   endtask

   task automatic wait_reports_done();
      req_valid <= 1'b0;
      do @(negedge clock); while (reports_due.size() != 0);
   endtask

   task automatic run_random(input int unsigned count);
      repeat (count) send_item(random_item());
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (reports_due.size() == 0) begin
            $error("result item arrived with no item outstanding");
            mismatches++;
         end else begin
            want = reports_due.pop_front();
            reports_seen++;
            check_field("axis_state", 8'(want.axis_state), 8'(rsp_item.axis_state));
            check_field("fault_active", 8'(want.fault_active), 8'(rsp_item.fault_active));
            check_field("entry_action", 8'(want.entry_action), 8'(rsp_item.entry_action));
            check_field("power_cmd", 8'(want.power_cmd), 8'(rsp_item.power_cmd));
            check_field("fault_code", 8'(want.fault_code), 8'(rsp_item.fault_code));
            check_field("ready_for_loop", 8'(want.ready_for_loop),
                        8'(rsp_item.ready_for_loop));
            check_field("open_loop_drive", 8'(want.open_loop_drive),
                        8'(rsp_item.open_loop_drive));
            check_field("outer_loop_run", 8'(want.outer_loop_run),
                        8'(rsp_item.outer_loop_run));
         end
      end
   end

   task automatic test_boot_and_idle();
      send_item(make_tick(1'b0, CAL_RUNNING, 1'b0, 1'b0, 1'b0));
      send_item(make_request(ST_OFFS));
      send_item(make_tick(1'b1, CAL_RUNNING, 1'b0, 1'b0, 1'b0));
      send_item(make_tick(1'b0, CAL_RUNNING, 1'b0, 1'b0, 1'b0));
      send_item(make_tick(1'b0, CAL_UNUSED, 1'b1, 1'b1, 1'b1));
      send_item(make_tick(1'b0, CAL_RUNNING, 1'b1, 1'b1, 1'b1));
      // Done with a calibration missing drops back to idle.
      send_item(make_tick(1'b0, CAL_DONE, 1'b1, 1'b0, 1'b1));
      send_item(make_request(REQ_UNDEFINED));
      send_item(make_tick(1'b0, CAL_RUNNING, 1'b1, 1'b1, 1'b1));
      send_item(make_request(ST_MCAL));
      send_item(make_tick(1'b0, CAL_RUNNING, 1'b0, 1'b1, 1'b1));
      send_item(make_tick(1'b0, CAL_RUNNING, 1'b1, 1'b1, 1'b1));
      send_item(make_tick(1'b0, CAL_DONE, 1'b1, 1'b1, 1'b0));
      send_item(make_request(ST_ECAL));
      send_item(make_tick(1'b0, CAL_RUNNING, 1'b1, 1'b0, 1'b1));
      send_item(make_tick(1'b0, CAL_RUNNING, 1'b1, 1'b1, 1'b1));
      send_item(make_tick(1'b0, CAL_DONE, 1'b0, 1'b1, 1'b1));
      send_item(make_request(ST_OPENL));
      send_item(make_tick(1'b0, CAL_RUNNING, 1'b1, 1'b1, 1'b1));
      send_item(make_tick(1'b0, CAL_RUNNING, 1'b1, 1'b1, 1'b1));
      send_item(make_request(ST_IDLE));
      send_item(make_tick(1'b0, CAL_RUNNING, 1'b1, 1'b1, 1'b1));
   endtask

   task automatic test_random_wander();
      run_random(300);
      // Let the block run dry before going on.
      wait_reports_done();
      stall_pct = 0;
      run_random(200);
      stall_pct = 23;
      run_random(300);
   endtask

   task automatic test_ready_hold();
      allow_ready = 1'b1;
      while (axis_now.state != ST_READY) begin
         case (axis_now.state)
            ST_BOOT: send_item(make_tick(1'b1, CAL_RUNNING, 1'b1, 1'b1, 1'b1));
            ST_IDLE: begin
               if (axis_now.pending != ST_OFFS) send_item(make_request(ST_OFFS));
               else send_item(make_tick(1'b0, CAL_RUNNING, 1'b1, 1'b1, 1'b1));
            end
            ST_OFFS, ST_MCAL, ST_ECAL:
               send_item(make_tick(1'b0, CAL_DONE, 1'b1, 1'b1, 1'b1));
            default: begin
               if (axis_now.pending != ST_IDLE) send_item(make_request(ST_IDLE));
               else send_item(make_tick(1'b0, CAL_RUNNING, 1'b1, 1'b1, 1'b1));
            end
         endcase
      end
      run_random(100);
   endtask

   task automatic test_closed_loop();
      allow_closed = 1'b1;
      send_item(make_request(ST_CLOSED));
      send_item(make_tick(1'b0, CAL_RUNNING, 1'b1, 1'b1, 1'b1));
      run_random(100);
   endtask

   task automatic test_fault_absorb();
      req_item_type it;
      allow_fault       = 1'b1;
      it                = make_tick(1'b0, CAL_RUNNING, 1'b1, 1'b1, 1'b1);
      it.external_fault = 1'b1;
      send_item(it);
      send_item(make_tick(1'b0, CAL_RUNNING, 1'b1, 1'b1, 1'b1));
      send_item(make_request(ST_IDLE));
      send_item(make_tick(1'b1, CAL_FAILED, 1'b0, 1'b0, 1'b0));
      run_random(100);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_boot_and_idle();
      test_random_wander();
      test_ready_hold();
      test_closed_loop();
      test_fault_absorb();
      wait_reports_done();
      repeat (8) @(negedge clock);
      if (reports_due.size() != 0) begin
         $error("%0d result items never arrived", reports_due.size());
         mismatches++;
      end
      $display("Sent %0d ticks and %0d state requests, checked %0d result items.",
               ticks_sent, requests_sent, reports_seen);
      $display("Visited %0d of 12 axis states, ending in the latched fault state.",
               $countones(states_seen));
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
